>>> hdl/bis_pkg.sv
// Package for the batch integer sorter.
// Holds the word types of both ports and the link type between sort cells.
// No dependencies.
package bis_pkg;

    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     batch_end;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     run_end;
        logic                     overflowed;
    } t_out_word;

    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] val;
    } t_link;

endpackage

>>> hdl/bis_cell.sv
// One cell of the systolic insertion chain of the batch integer sorter.
// Keeps the smaller of held and new word, passes the larger; i_shift loads i_right.
// Depends on bis_pkg.
module bis_cell
    import bis_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_link i_left,
    input  t_link i_right,
    output t_link o_held,
    output t_link o_pass
);

    t_link r_held;
    t_link r_pass;
    t_link n_held;
    t_link n_pass;

    always_comb begin
        n_held     = r_held;
        n_pass     = r_pass;
        n_pass.vld = 1'b0;
        if (i_shift) begin
            n_held = i_right;
        end else if (i_left.vld) begin
            if (!r_held.vld) begin
                n_held = i_left;
            end else if (i_left.val < r_held.val) begin
                n_held = i_left;
                n_pass = r_held;
            end else begin
                n_pass = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held.val <= n_held.val;
        r_pass.val <= n_pass.val;
        if (!i_rst_n) begin
            r_held.vld <= 1'b0;
            r_pass.vld <= 1'b0;
        end else begin
            r_held.vld <= n_held.vld;
            r_pass.vld <= n_pass.vld;
        end
    end

    assign o_held = r_held;
    assign o_pass = r_pass;

endmodule

>>> hdl/batch_integer_sorter.sv
// Batch integer sorter: a chain of MAX_ITEMS insertion cells; depends on bis_pkg and bis_cell.
// Loading takes one word per cycle while busy is low.
// After the closing word the chain settles, then the stored results stream out one per cycle.
// Busy stays high while the chain settles and drains, and results cannot be stalled.
// Reset empties the chain and clears count and overflow.
module batch_integer_sorter
    import bis_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 64
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_data,
    output logic      o_strobe,
    output t_out_word o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SETTLE,
        S_DRAIN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_wait;
    logic             r_ovf;
    logic             r_strobe;
    t_out_word        r_result;

    t_link held [MAX_ITEMS];
    t_link pass [MAX_ITEMS];
    t_link feed;
    t_link empty_link;
    logic  accept;
    logic  room;
    logic  shift;

    assign accept     = start && (r_state == S_LOAD);
    assign room       = (r_count != CNT_MAX);
    assign shift      = (r_state == S_DRAIN);
    assign feed.vld   = accept && room;
    assign feed.val   = i_data.value;
    assign empty_link = '0;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        bis_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_left  ((g == 0) ? feed : pass[(g == 0) ? 0 : g - 1]),
            .i_right ((g == MAX_ITEMS - 1) ? empty_link
                                           : held[(g == MAX_ITEMS - 1) ? g : g + 1]),
            .o_held  (held[g]),
            .o_pass  (pass[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_wait   <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe              <= 1'b0;
            r_result.sorted_value <= held[0].val;
            r_result.run_end      <= (r_wait == CNT_ONE);
            r_result.overflowed   <= r_ovf;
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (room) begin
                            r_count <= r_count + CNT_ONE;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_data.batch_end) begin
                            r_wait  <= room ? r_count + CNT_ONE : r_count;
                            r_state <= S_SETTLE;
                        end
                    end
                end
                S_SETTLE: begin
                    if (r_wait == '0) begin
                        r_wait  <= r_count;
                        r_state <= S_DRAIN;
                    end else begin
                        r_wait <= r_wait - CNT_ONE;
                    end
                end
                S_DRAIN: begin
                    r_strobe <= 1'b1;
                    r_wait   <= r_wait - CNT_ONE;
                    if (r_wait == CNT_ONE) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_LOAD);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> verif/testbench.sv
// Testbench for batch_integer_sorter: feeds batches of signed words and checks that
// each batch comes back in ascending order with its last and overflow flags.
// Depends on bis_pkg and the batch_integer_sorter RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bis_pkg::*;

    localparam int unsigned MAX_ITEMS    = 64;
    localparam int unsigned GAP_MAX      = 6;
    localparam int unsigned TARGET_WORDS = 220;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES  = 3 * MAX_ITEMS + 20;

    typedef enum int unsigned {
        VAL_WIDE,
        VAL_NARROW,
        VAL_EXTREME
    } t_value_mix;

    typedef struct {
        t_in_word    word;
        int unsigned gap;
        bit          wait_drained;
    } t_feed_item;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_word  i_data  = '0;
    logic      busy;
    logic      o_strobe;
    t_out_word o_result;

    t_feed_item         feed_queue[$];
    t_out_word          expected_sorted[$];
    logic signed [31:0] batch_store[MAX_ITEMS];
    int unsigned        batch_count   = 0;
    bit                 batch_dropped = 1'b0;

    int unsigned words_queued = 0;
    int unsigned words_taken  = 0;
    int unsigned fail_count   = 0;
    int unsigned idle_cycles  = 0;
    bit          took_word    = 1'b0;

    t_feed_item  cur_item;
    bit          have_item = 1'b0;
    int unsigned gap_left  = 0;

    batch_integer_sorter #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Stores one accepted word; the closing word sorts the batch into the expected results.
    function automatic void absorb_word(t_in_word w);
        logic signed [31:0] v;
        int unsigned        k;
        int unsigned        p;
        t_out_word          exp_word;
        if (batch_count < MAX_ITEMS) begin
            batch_store[batch_count] = w.value;
            batch_count++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (w.batch_end) begin
            for (k = 1; k < batch_count; k++) begin
                v = batch_store[k];
                p = k;
                while (p > 0 && v < batch_store[p-1]) begin
                    batch_store[p] = batch_store[p-1];
                    p--;
                end
                batch_store[p] = v;
            end
            for (k = 0; k < batch_count; k++) begin
                exp_word.sorted_value = batch_store[k];
                exp_word.run_end      = (k + 1 == batch_count);
                exp_word.overflowed   = batch_dropped;
                expected_sorted       = {expected_sorted, exp_word};
            end
            batch_count   = 0;
            batch_dropped = 1'b0;
        end
    endfunction

    function automatic logic signed [31:0] pick_value(t_value_mix mix);
        case (mix)
            VAL_WIDE: begin
                return $urandom;
            end
            VAL_NARROW: begin
                return int'($urandom_range(8)) - 4;
            end
            default: begin
                case ($urandom_range(5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0000_0000;
                    3: return -32'sd1;
                    4: return 32'sd1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic push_word(logic signed [31:0] v, bit last, int unsigned gap,
                             bit wait_drained);
        t_feed_item it;
        it.word         = '{value: v, batch_end: last};
        it.gap          = gap;
        it.wait_drained = wait_drained;
        feed_queue      = {feed_queue, it};
        words_queued++;
    endtask

    task automatic push_batch(int unsigned n, t_value_mix mix, bit quiet, bit wait_drained);
        int unsigned i;
        for (i = 0; i < n; i++) begin
            push_word(pick_value(mix), i == n - 1, quiet ? 0 : $urandom_range(GAP_MAX),
                      wait_drained && i == 0);
        end
    endtask

    initial begin
        int unsigned n;
        bit          full_done;
        bit          spill_done;
        bit          first;
        t_value_mix  mix;
        full_done  = 1'b0;
        spill_done = 1'b0;
        first      = 1'b1;

        push_word(32'sh7fff_ffff, 1'b0, 0, 1'b0);
        push_word(32'sh8000_0000, 1'b0, 0, 1'b0);
        push_word(32'sh0000_0000, 1'b0, 1, 1'b0);
        push_word(-32'sd1,        1'b0, 0, 1'b0);
        push_word(32'sd1,         1'b0, 3, 1'b0);
        push_word(32'sh7fff_ffff, 1'b0, 0, 1'b0);
        push_word(32'sh8000_0000, 1'b1, 0, 1'b0);
        push_word(32'sh7fff_ffff, 1'b1, 0, 1'b0);
        push_word(32'sh8000_0000, 1'b1, 2, 1'b0);
        push_word(32'sd5,         1'b0, 0, 1'b0);
        push_word(32'sd5,         1'b1, 0, 1'b0);
        push_word(-32'sd2,        1'b0, 0, 1'b0);
        push_word(-32'sd1,        1'b0, 0, 1'b0);
        push_word(32'sd0,         1'b0, 0, 1'b0);
        push_word(32'sd1,         1'b1, 0, 1'b0);
        push_word(32'sd3,         1'b0, 4, 1'b0);
        push_word(32'sd2,         1'b0, 0, 1'b0);
        push_word(32'sd1,         1'b0, 6, 1'b0);
        push_word(32'sd0,         1'b1, 0, 1'b0);

        while (words_queued < TARGET_WORDS) begin
            mix = t_value_mix'($urandom_range(2));
            if (!full_done && words_queued > 60) begin
                n         = MAX_ITEMS;
                full_done = 1'b1;
            end else if (!spill_done && words_queued > 120) begin
                n          = MAX_ITEMS + 2 + $urandom_range(4);
                spill_done = 1'b1;
            end else begin
                n = 1 + $urandom_range(11);
            end
            push_batch(n, mix, $urandom_range(2) == 0, first || $urandom_range(4) == 0);
            first = 1'b0;
        end

        @(posedge i_clk);
        while (!i_rst_n || words_taken != words_queued || expected_sorted.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        logic     next_start;
        t_in_word next_data;
        next_start = 1'b0;
        next_data  = i_data;
        if (!i_rst_n) begin
            have_item = 1'b0;
            gap_left  = 0;
        end else if (start && !took_word) begin
            next_start = 1'b1;
        end else begin
            if (!have_item && feed_queue.size() > 0) begin
                cur_item  = feed_queue.pop_front();
                have_item = 1'b1;
                gap_left  = cur_item.gap;
            end
            if (have_item) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(cur_item.wait_drained && expected_sorted.size() != 0)) begin
                    next_start = 1'b1;
                    next_data  = cur_item.word;
                    have_item  = 1'b0;
                end
            end
        end
        start  <= next_start;
        i_data <= next_data;
    end

    always @(posedge i_clk) begin
        t_out_word want;
        took_word = i_rst_n && start && !busy;
        if (took_word) begin
            absorb_word(i_data);
            words_taken++;
        end
        if (i_rst_n && o_strobe) begin
            if (expected_sorted.size() == 0) begin
                $error("unexpected result word: sorted_value %0d", o_result.sorted_value);
                fail_count++;
            end else begin
                want = expected_sorted.pop_front();
                if (o_result.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, o_result.sorted_value);
                    fail_count++;
                end
                if (o_result.run_end !== want.run_end) begin
                    $error("run_end: expected %0b, got %0b", want.run_end, o_result.run_end);
                    fail_count++;
                end
                if (o_result.overflowed !== want.overflowed) begin
                    $error("overflowed: expected %0b, got %0b",
                           want.overflowed, o_result.overflowed);
                    fail_count++;
                end
            end
        end
        if (i_rst_n) begin
            if (took_word || o_strobe) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

>>> files.f
hdl/bis_pkg.sv
hdl/bis_cell.sv
hdl/batch_integer_sorter.sv
verif/testbench.sv
